[src/fqt_pkg.sv]
// Package: shared types, character constants and hex digit decoding for the query tokenizer.
`default_nettype none

package fqt_pkg;

   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_EQUALS    = 8'h3D;
   localparam logic [7:0] CH_PERCENT   = 8'h25;
   localparam logic [7:0] CH_PLUS      = 8'h2B;
   localparam logic [7:0] CH_SPACE     = 8'h20;

   localparam logic [7:0] SEP_RESET    = 8'h26;

   // Progress of a percent escape in the value.
   localparam logic [1:0] PCT_NONE = 2'd0;
   localparam logic [1:0] PCT_HIGH = 2'd1;
   localparam logic [1:0] PCT_LOW  = 2'd2;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_word_type;

   typedef struct packed {
      logic       byte_valid;
      logic [7:0] out_byte;
      logic       in_value_part;
      logic       pair_end;
      logic       format_error;
      logic       out_last;
   } rsp_word_type;

   typedef struct packed {
      logic       in_value_now;
      logic       escape_pending;
      logic       key_started;
      logic [1:0] percent_phase;
      logic [3:0] high_nibble;
   } parse_state_type;

   typedef struct packed {
      logic         emit;
      rsp_word_type word;
   } step_result_type;

   // Bit 4 flags a valid hex digit, bits 3:0 carry its value.
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, 4'(c - 8'h30)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r = {1'b1, 4'(c - 8'h57)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r = {1'b1, 4'(c - 8'h37)};
      end
      return r;
   endfunction

endpackage

`default_nettype wire

[src/fqt_step.sv]
// Module: combinational parse step that turns one raw byte and the parse state into a result.
`default_nettype none

module fqt_step (
   input  var fqt_pkg::parse_state_type state_cur,
   input  var fqt_pkg::req_word_type    word_in,
   input  wire logic [7:0]              pair_separator,
   output fqt_pkg::parse_state_type     state_next,
   output fqt_pkg::step_result_type     result
);

   logic [7:0] b;
   logic       esc_in;
   logic       is_sep;
   logic       vset;
   logic       vpart;
   logic [4:0] hex;

   assign b      = word_in.in_byte;
   assign esc_in = state_cur.escape_pending;
   assign is_sep = !esc_in && (b != fqt_pkg::CH_BACKSLASH) && (b == pair_separator);
   assign hex    = fqt_pkg::hex_digit(b);

   always_comb begin
      state_next = state_cur;
      state_next.escape_pending = !esc_in && (b == fqt_pkg::CH_BACKSLASH);
      result = '0;
      vset   = 1'b0;
      vpart  = 1'b0;

      if (is_sep) begin
         result.emit = 1'b1;
         result.word.pair_end = 1'b1;
         result.word.format_error = !state_cur.in_value_now ||
                                    (state_cur.percent_phase != fqt_pkg::PCT_NONE);
         vpart = state_cur.in_value_now;
         vset  = 1'b1;
         state_next.in_value_now  = 1'b0;
         state_next.key_started   = 1'b0;
         state_next.percent_phase = fqt_pkg::PCT_NONE;
         state_next.high_nibble   = 4'd0;
      end else if (!state_cur.in_value_now) begin
         if (!esc_in && b == fqt_pkg::CH_EQUALS) begin
            state_next.in_value_now = 1'b1;
         end else if (!state_cur.key_started && b == fqt_pkg::CH_SPACE) begin
            // Leading key spaces are dropped.
         end else begin
            state_next.key_started = 1'b1;
            result.emit = 1'b1;
            result.word.byte_valid = 1'b1;
            result.word.out_byte = b;
            vset = 1'b1;
         end
      end else if (state_cur.percent_phase == fqt_pkg::PCT_HIGH) begin
         if (!hex[4]) begin
            result.emit = 1'b1;
            result.word.format_error = 1'b1;
            state_next.percent_phase = fqt_pkg::PCT_NONE;
         end else begin
            state_next.high_nibble   = hex[3:0];
            state_next.percent_phase = fqt_pkg::PCT_LOW;
         end
      end else if (state_cur.percent_phase == fqt_pkg::PCT_LOW) begin
         state_next.percent_phase = fqt_pkg::PCT_NONE;
         result.emit = 1'b1;
         if (!hex[4]) begin
            result.word.format_error = 1'b1;
         end else begin
            result.word.byte_valid = 1'b1;
            result.word.out_byte = {state_cur.high_nibble, hex[3:0]};
            vpart = 1'b1;
            vset  = 1'b1;
         end
      end else if (b == fqt_pkg::CH_PERCENT) begin
         state_next.percent_phase = fqt_pkg::PCT_HIGH;
      end else begin
         result.emit = 1'b1;
         result.word.byte_valid = 1'b1;
         result.word.out_byte = (b == fqt_pkg::CH_PLUS) ? fqt_pkg::CH_SPACE : b;
         vpart = 1'b1;
         vset  = 1'b1;
      end

      // A separator reports the part before it; other dataless results, the part after it.
      result.word.in_value_part = vset ? vpart : state_next.in_value_now;

      if (word_in.in_last) begin
         result.emit = 1'b1;
         result.word.pair_end = 1'b1;
         result.word.out_last = 1'b1;
         if (is_sep || !state_next.in_value_now ||
             state_next.percent_phase != fqt_pkg::PCT_NONE) begin
            result.word.format_error = 1'b1;
         end
         state_next.escape_pending = 1'b0;
         state_next.in_value_now   = 1'b0;
         state_next.key_started    = 1'b0;
         state_next.percent_phase  = fqt_pkg::PCT_NONE;
         state_next.high_nibble    = 4'd0;
      end
   end

endmodule

`default_nettype wire

[src/form_query_tokenizer_core.sv]
// Module: top level of the streaming form-encoded query tokenizer.
//
//   Channel   Direction  Handshake            Word
//   req       in         req_valid/req_ready  in_byte, in_last
//   rsp       out        rsp_valid/rsp_ready  byte_valid, out_byte, in_value_part,
//                                             pair_end, format_error, out_last
//   csr       in         csr_wr_en            pair_separator (8 bits, reset '&')
//
// Every accepted word passes through an input register and, if it produces a
// result, moves on into the result register once that slot is free. One word
// is taken each cycle unless a stalled result blocks it. The parse state lives in
// a single register set that is updated as each word leaves the input register.
// Words that produce no result never wait for the result register. When the
// consumer stalls with a result pending, the input register holds its word and
// req_ready falls only for words that need the result slot. Reset is
// synchronous; it empties both registers and restores the separator to '&'.
`default_nettype none

module form_query_tokenizer_core (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  var fqt_pkg::req_word_type  req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output fqt_pkg::rsp_word_type      rsp_data,
   input  wire logic                  csr_wr_en,
   input  wire logic [7:0]            csr_wr_data
);

   logic                     in_valid_ff;
   logic                     in_valid_in;
   fqt_pkg::req_word_type    in_word_ff;
   logic                     out_valid_ff;
   logic                     out_valid_in;
   fqt_pkg::rsp_word_type    out_word_ff;
   fqt_pkg::parse_state_type state_ff;
   fqt_pkg::parse_state_type state_in;
   logic [7:0]               sep_ff;
   logic [7:0]               sep_in;
   fqt_pkg::step_result_type step_res;
   logic                     advance;
   logic                     out_free;

   fqt_step u_step (
      .state_cur      (state_ff),
      .word_in        (in_word_ff),
      .pair_separator (sep_ff),
      .state_next     (state_in),
      .result         (step_res)
   );

   // The result slot is free if empty or being drained this cycle.
   assign out_free  = !out_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && (!step_res.emit || out_free);
   assign req_ready = !in_valid_ff || advance;

   assign in_valid_in  = req_valid || (in_valid_ff && !advance);
   assign out_valid_in = (advance && step_res.emit) || (out_valid_ff && !rsp_ready);
   assign sep_in       = csr_wr_en ? csr_wr_data : sep_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
         sep_ff       <= fqt_pkg::SEP_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         sep_ff       <= sep_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_word_ff <= req_data;
      end
      if (advance && step_res.emit) begin
         out_word_ff <= step_res.word;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_word_ff;

endmodule

`default_nettype wire

[src/fqt_checker.sv]
// Module: port-level checks for the tokenizer core, bound to the top level.
`default_nettype none

module fqt_checker (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_ready,
   input var fqt_pkg::rsp_word_type  rsp_data
);

   // A result held back by the consumer must not change.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result word changed while stalled");

   // A result without a data byte carries a zero byte.
   a_zero_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.byte_valid |-> rsp_data.out_byte == 8'd0)
      else $error("out_byte not zero without a data byte");

   // The final result of a buffer always closes its pair.
   a_last_closes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.out_last |-> rsp_data.pair_end)
      else $error("final result does not close the pair");

   // An error inside a pair can only be a bad hex digit in the value.
   a_mid_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.pair_end && rsp_data.format_error
      |-> !rsp_data.byte_valid && rsp_data.in_value_part)
      else $error("mid-pair error outside a value escape");

   // Reset empties the result register.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind form_query_tokenizer_core fqt_checker u_fqt_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire

[sim/testbench.sv]
// Testbench for the form-encoded query tokenizer: random and directed query bytes, scoreboard.
`timescale 1ns / 1ps

module testbench;

   // The run is ended by the watchdog if it goes beyond this many cycles.
   localparam int CYCLE_LIMIT   = 400000;
   // Length of the one long receiver hold-off, in cycles.
   localparam int LONG_HOLD     = 300;
   // Minimum number of query bytes generated per separator setting in the random part.
   localparam int BYTES_PER_SET = 185;
   localparam int SEP_SETTINGS  = 8;
   // Extra cycles that cover the input and result registers of the block.
   localparam int SETTLE_CYCLES = 6;

   // The scoreboard predicts the token stream from the accepted query bytes
   // and checks every result word against the oldest predicted token.
   class token_scoreboard;
      logic [7:0]            separator;
      logic                  value_part_now;
      logic                  escape_open;
      logic                  key_seen;
      logic [1:0]            pct_phase;
      logic [3:0]            high_digit;
      fqt_pkg::rsp_word_type expected_tokens[$];
      int                    mismatches;
      int                    bytes_seen;
      int                    tokens_seen;
      int                    errors_flagged;

      function new();
         separator      = fqt_pkg::SEP_RESET;
         escape_open    = 1'b0;
         mismatches     = 0;
         bytes_seen     = 0;
         tokens_seen    = 0;
         errors_flagged = 0;
         clear_pair();
      endfunction

      function void clear_pair();
         value_part_now = 1'b0;
         key_seen       = 1'b0;
         pct_phase      = fqt_pkg::PCT_NONE;
         high_digit     = 4'd0;
      endfunction

      // Returns 1 and the digit value when c is a hex digit in either case.
      function bit hex_ok(input logic [7:0] c, output logic [3:0] v);
         v = 4'd0;
         if (c >= "0" && c <= "9") begin
            v = 4'(c - "0");
            return 1'b1;
         end
         if (c >= "a" && c <= "f") begin
            v = 4'(c - "a" + 8'd10);
            return 1'b1;
         end
         if (c >= "A" && c <= "F") begin
            v = 4'(c - "A" + 8'd10);
            return 1'b1;
         end
         return 1'b0;
      endfunction

      // Advances the parse state by one query byte and queues the token it
      // causes, if any.
      function void accept_query_byte(input fqt_pkg::req_word_type w);
         logic [7:0]            b;
         logic                  esc_in;
         logic                  emit;
         logic                  is_sep;
         logic                  part_set;
         logic [3:0]            nib;
         fqt_pkg::rsp_word_type t;
         b        = w.in_byte;
         esc_in   = escape_open;
         emit     = 1'b0;
         is_sep   = 1'b0;
         part_set = 1'b0;
         t        = '0;
         bytes_seen++;
         escape_open = !esc_in && b == fqt_pkg::CH_BACKSLASH;
         if (!esc_in && b != fqt_pkg::CH_BACKSLASH && b == separator) begin
            is_sep          = 1'b1;
            emit            = 1'b1;
            t.pair_end      = 1'b1;
            t.format_error  = !value_part_now || pct_phase != fqt_pkg::PCT_NONE;
            t.in_value_part = value_part_now;
            part_set        = 1'b1;
            clear_pair();
         end else if (!value_part_now) begin
            if (!esc_in && b == fqt_pkg::CH_EQUALS) begin
               value_part_now = 1'b1;
            end else if (!key_seen && b == fqt_pkg::CH_SPACE) begin
               // Leading spaces of the key are dropped.
            end else begin
               key_seen     = 1'b1;
               emit         = 1'b1;
               t.byte_valid = 1'b1;
               t.out_byte   = b;
               part_set     = 1'b1;
            end
         end else if (pct_phase == fqt_pkg::PCT_HIGH) begin
            if (!hex_ok(b, nib)) begin
               emit           = 1'b1;
               t.format_error = 1'b1;
               pct_phase      = fqt_pkg::PCT_NONE;
            end else begin
               high_digit = nib;
               pct_phase  = fqt_pkg::PCT_LOW;
            end
         end else if (pct_phase == fqt_pkg::PCT_LOW) begin
            pct_phase = fqt_pkg::PCT_NONE;
            emit      = 1'b1;
            if (!hex_ok(b, nib)) begin
               t.format_error = 1'b1;
            end else begin
               t.byte_valid    = 1'b1;
               t.out_byte      = {high_digit, nib};
               t.in_value_part = 1'b1;
               part_set        = 1'b1;
            end
         end else if (b == fqt_pkg::CH_PERCENT) begin
            pct_phase = fqt_pkg::PCT_HIGH;
         end else begin
            emit            = 1'b1;
            t.byte_valid    = 1'b1;
            t.out_byte      = (b == fqt_pkg::CH_PLUS) ? fqt_pkg::CH_SPACE : b;
            t.in_value_part = 1'b1;
            part_set        = 1'b1;
         end
         if (!part_set) begin
            t.in_value_part = value_part_now;
         end
         if (w.in_last) begin
            emit       = 1'b1;
            t.pair_end = 1'b1;
            if (is_sep || !value_part_now || pct_phase != fqt_pkg::PCT_NONE) begin
               t.format_error = 1'b1;
            end
            escape_open = 1'b0;
            clear_pair();
         end
         t.out_last = w.in_last;
         if (emit) begin
            expected_tokens.push_back(t);
         end
      endfunction

      function void compare_field(input string field, input int unsigned want,
                                  input int unsigned got);
         if (want != got) begin
            mismatches++;
            if (mismatches <= 100) begin
               $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
            end
         end
      endfunction

      function void check_token(input fqt_pkg::rsp_word_type got);
         fqt_pkg::rsp_word_type want;
         tokens_seen++;
         if (got.format_error) begin
            errors_flagged++;
         end
         if (expected_tokens.size() == 0) begin
            mismatches++;
            if (mismatches <= 100) begin
               $display("%0t: unexpected token, expected none actual %h", $time, got);
            end
            return;
         end
         want = expected_tokens.pop_front();
         compare_field("byte_valid", 32'(want.byte_valid), 32'(got.byte_valid));
         compare_field("out_byte", 32'(want.out_byte), 32'(got.out_byte));
         compare_field("in_value_part", 32'(want.in_value_part), 32'(got.in_value_part));
         compare_field("pair_end", 32'(want.pair_end), 32'(got.pair_end));
         compare_field("format_error", 32'(want.format_error), 32'(got.format_error));
         compare_field("out_last", 32'(want.out_last), 32'(got.out_last));
      endfunction
   endclass

   logic                  clock;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic                  req_ready;
   fqt_pkg::req_word_type req_data    = '0;
   logic                  rsp_valid;
   logic                  rsp_ready   = 1'b0;
   fqt_pkg::rsp_word_type rsp_data;
   logic                  csr_wr_en   = 1'b0;
   logic [7:0]            csr_wr_data = fqt_pkg::SEP_RESET;

   token_scoreboard       sb = new();
   fqt_pkg::req_word_type query_stream[$];
   int                    cycle_count     = 0;
   bit                    long_hold_armed = 1'b0;
   bit                    long_hold_done  = 1'b0;

   form_query_tokenizer_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Watchdog: a hung handshake or a lost token ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Every word that crosses either channel is seen here, at the same edge
   // at which the block takes or gives it. Input words feed the prediction,
   // result words are checked against it.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            sb.accept_query_byte(req_data);
         end
         if (rsp_valid && rsp_ready) begin
            sb.check_token(rsp_data);
         end
      end
   end

   // The receiver picks a stall pattern for a stretch of cycles, then picks
   // another one. Once in the run it holds off for a long stretch so that
   // the block fills up and has to stall its input.
   initial begin : rsp_stall_pattern
      int mode;
      int span;
      mode = 0;
      span = 0;
      @(posedge clock);
      forever begin
         if (span == 0) begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(16, 96);
         end
         span--;
         if (long_hold_armed) begin
            long_hold_armed = 1'b0;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            long_hold_done = 1'b1;
         end else begin
            case (mode)
               0: begin
                  rsp_ready <= 1'b1;
               end
               1: begin
                  rsp_ready <= 1'($urandom_range(0, 1));
               end
               2: begin
                  rsp_ready <= ($urandom_range(0, 3) == 0);
               end
               default: begin
                  rsp_ready <= (cycle_count % 4 != 3);
               end
            endcase
            @(posedge clock);
         end
      end
   end

   function automatic void push_byte(input logic [7:0] b, input logic last);
      fqt_pkg::req_word_type w;
      w.in_byte = b;
      w.in_last = last;
      query_stream.push_back(w);
   endfunction

   // Mostly letters, sometimes a digit or any byte at all.
   function automatic logic [7:0] plain_char();
      case ($urandom_range(0, 7))
         0: return 8'($urandom_range(0, 255));
         1: return 8'("0" + $urandom_range(0, 9));
         default: return 8'("a" + $urandom_range(0, 25));
      endcase
   endfunction

   function automatic logic [7:0] hex_char();
      int v;
      v = $urandom_range(0, 15);
      if (v < 10) begin
         return 8'("0" + v);
      end
      return 8'(($urandom_range(0, 1) ? "A" : "a") + v - 10);
   endfunction

   // One key=value pair without its separator. Most pairs are well formed;
   // some lack the '=', carry escapes or a broken percent escape.
   function automatic void add_pair();
      int n;
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
      repeat (n) push_byte(fqt_pkg::CH_SPACE, 1'b0);
      n = $urandom_range(0, 5);
      repeat (n) begin
         if ($urandom_range(0, 7) == 0) begin
            push_byte(fqt_pkg::CH_BACKSLASH, 1'b0);
            push_byte(8'($urandom_range(0, 255)), 1'b0);
         end else begin
            push_byte(($urandom_range(0, 9) == 0) ? fqt_pkg::CH_SPACE : plain_char(), 1'b0);
         end
      end
      if ($urandom_range(0, 9) != 0) begin
         push_byte(fqt_pkg::CH_EQUALS, 1'b0);
      end
      n = $urandom_range(0, 6);
      repeat (n) begin
         case ($urandom_range(0, 9))
            0: begin
               push_byte(fqt_pkg::CH_PLUS, 1'b0);
            end
            1, 2: begin
               push_byte(fqt_pkg::CH_PERCENT, 1'b0);
               push_byte(hex_char(), 1'b0);
               push_byte(hex_char(), 1'b0);
            end
            3: begin
               push_byte(fqt_pkg::CH_PERCENT, 1'b0);
               push_byte($urandom_range(0, 1) ? hex_char() : plain_char(), 1'b0);
               push_byte(plain_char(), 1'b0);
            end
            4: begin
               push_byte(fqt_pkg::CH_BACKSLASH, 1'b0);
               push_byte(8'($urandom_range(0, 255)), 1'b0);
            end
            5: begin
               push_byte(fqt_pkg::CH_EQUALS, 1'b0);
            end
            default: begin
               push_byte(plain_char(), 1'b0);
            end
         endcase
      end
   endfunction

   // Buffers of one to five pairs, split by the separator, the last pair only
   // sometimes closed by it, and ended by a final byte; one buffer in ten is plain noise.
   function automatic void build_query_stream(input int target, input logic [7:0] sep);
      int start;
      int pairs;
      int k;
      while (query_stream.size() < target) begin
         start = query_stream.size();
         if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 12)) push_byte(8'($urandom_range(0, 255)), 1'b0);
            if ($urandom_range(0, 3) != 0) begin
               query_stream[$].in_last = 1'b1;
            end
         end else begin
            pairs = $urandom_range(1, 5);
            for (k = 0; k < pairs; k++) begin
               add_pair();
               if (k < pairs - 1 || $urandom_range(0, 4) == 0) begin
                  push_byte(sep, 1'b0);
               end
            end
            if (query_stream.size() == start) begin
               push_byte(plain_char(), 1'b0);
            end
            query_stream[$].in_last = 1'b1;
         end
      end
   endfunction

   // Offers the queued words in bursts of random length with random gaps.
   // A word stays on the bus unchanged until the block takes it.
   task automatic send_query_stream();
      int idx;
      int burst;
      int gap;
      idx = 0;
      while (idx < query_stream.size()) begin
         burst = $urandom_range(1, 24);
         while (burst > 0 && idx < query_stream.size()) begin
            req_valid <= 1'b1;
            req_data  <= query_stream[idx];
            do @(posedge clock); while (!req_ready);
            idx++;
            burst--;
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_valid <= 1'b0;
      query_stream.delete();
   endtask

   // First waits for the edge at which the last accepted word is predicted, then
   // until every predicted token has come out, then lets the last silent
   // word leave the pipeline before anything else changes.
   task automatic wait_idle();
      @(posedge clock);
      while (sb.expected_tokens.size() != 0 || rsp_valid) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_separator(input logic [7:0] sep);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= sep;
      @(posedge clock);
      csr_wr_en    <= 1'b0;
      sb.separator = sep;
   endtask

   initial begin : main_sequence
      logic [7:0] separator_plan [SEP_SETTINGS];
      int         p;
      separator_plan = '{fqt_pkg::SEP_RESET, 8'h00, 8'hFF, 8'h3B, fqt_pkg::CH_BACKSLASH,
                         fqt_pkg::CH_EQUALS, fqt_pkg::CH_PERCENT, 8'h00};
      separator_plan[SEP_SETTINGS-1] = 8'($urandom_range(0, 255));

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed words with the separator at its reset value. The first pair
      // has a dropped leading space, a plus and a valid percent escape.
      push_byte(fqt_pkg::CH_SPACE, 1'b0);
      push_byte("k", 1'b0);
      push_byte(fqt_pkg::CH_EQUALS, 1'b0);
      push_byte(fqt_pkg::CH_PLUS, 1'b0);
      push_byte(fqt_pkg::CH_PERCENT, 1'b0);
      push_byte("4", 1'b0);
      push_byte("F", 1'b0);
      push_byte(fqt_pkg::SEP_RESET, 1'b0);
      // An escaped separator inside the key, a bad hex digit in the value and
      // an escaped separator in the value, both backslashes passed through.
      push_byte(fqt_pkg::CH_BACKSLASH, 1'b0);
      push_byte(fqt_pkg::SEP_RESET, 1'b0);
      push_byte(fqt_pkg::CH_EQUALS, 1'b0);
      push_byte(fqt_pkg::CH_PERCENT, 1'b0);
      push_byte("g", 1'b0);
      push_byte(fqt_pkg::CH_BACKSLASH, 1'b0);
      push_byte(fqt_pkg::SEP_RESET, 1'b0);
      push_byte(fqt_pkg::SEP_RESET, 1'b0);
      // An empty pair, then a percent escape cut off by the separator.
      push_byte(fqt_pkg::SEP_RESET, 1'b0);
      push_byte(fqt_pkg::CH_EQUALS, 1'b0);
      push_byte(fqt_pkg::CH_PERCENT, 1'b0);
      push_byte("a", 1'b0);
      push_byte(fqt_pkg::SEP_RESET, 1'b0);
      // A key of the extreme byte values with no '=', closed by a separator
      // that is also the final byte of the buffer.
      push_byte(8'hFF, 1'b0);
      push_byte(8'h00, 1'b0);
      push_byte(fqt_pkg::CH_SPACE, 1'b0);
      push_byte(fqt_pkg::SEP_RESET, 1'b1);
      send_query_stream();
      wait_idle();

      // Random buffers under a range of separators, the extremes among them.
      // The long receiver hold-off is armed in the third setting.
      for (p = 0; p < SEP_SETTINGS; p++) begin
         write_separator(separator_plan[p]);
         build_query_stream(BYTES_PER_SET, separator_plan[p]);
         if (p == 2) begin
            long_hold_armed = 1'b1;
         end
         send_query_stream();
         wait_idle();
      end
      repeat (10) @(posedge clock);

      $display("Tokenized %0d query bytes under %0d separator settings, %0d tokens checked.",
               sb.bytes_seen, SEP_SETTINGS + 1, sb.tokens_seen);
      $display("%0d tokens flagged format errors; long receiver hold-off %0s.",
               sb.errors_flagged, long_hold_done ? "done" : "not done");
      if (sb.mismatches == 0 && sb.expected_tokens.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("%0d mismatches, %0d tokens never seen", sb.mismatches,
                  sb.expected_tokens.size());
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
